FILE: sv/quadratic_root_solver_assert.svh
// Assertion macros shared by the quadratic root solver RTL.
// Users need clk_i and rst_ni in scope; no other dependencies.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define QRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("quadratic root solver assertion failed");

// Implication with a fixed cycle delay, disabled during reset.
`define QRS_ASSERT_DLY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("quadratic root solver assertion failed");

`endif

FILE: sv/qrs_pkg.sv
// Package for the quadratic root solver: widths, types, codes and step functions.
// Used by every module of the block; depends on nothing.
package qrs_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int FRAC_OUT   = 16;
  localparam int ROOT_W     = COEF_WIDTH + 1;
  localparam int DISC_W     = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int NUM_W      = COEF_WIDTH + 2;
  localparam int DVD_W      = NUM_W + FRAC_OUT;
  localparam int DEN_W      = COEF_WIDTH + 1;
  localparam int SQ_STAGES  = (ROOT_W + 1) / 2;
  localparam int DV_STAGES  = (DVD_W + 1) / 2;
  localparam int LATENCY    = 3 + SQ_STAGES + 1 + DV_STAGES + 1;

  localparam logic [1:0] CNT_COMPLEX  = 2'd0;
  localparam logic [1:0] CNT_REPEAT   = 2'd1;
  localparam logic [1:0] CNT_DISTINCT = 2'd2;

  localparam logic [DVD_W-1:0] Q_POS_LIM = DVD_W'(32'h7fff_ffff);
  localparam logic [DVD_W-1:0] Q_NEG_LIM = DVD_W'(32'h8000_0000);

  typedef struct packed {
    logic                         degen;
    logic                         neg;
    logic                         zero;
    logic signed [COEF_WIDTH-1:0] a;
    logic signed [COEF_WIDTH-1:0] b;
  } side_t;

  typedef struct packed {
    logic [DISC_W-1:0] mag;
    side_t             sd;
  } disc_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    side_t             sd;
  } root_t;

  typedef struct packed {
    logic [DISC_W-1:0] rad;
    logic [ROOT_W-1:0] res;
    logic [REM_W-1:0]  rem;
  } sq_t;

  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic             neg;
  } ln_t;

  typedef struct packed {
    logic       degen;
    logic [1:0] count;
  } meta_t;

  typedef struct packed {
    ln_t [1:0] ln;
    meta_t     m;
  } dv_t;

  typedef struct packed {
    logic [1:0]         count;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic               degen;
    logic               sat;
  } res_t;

  function automatic logic [COEF_WIDTH-1:0] coef_mag(logic signed [COEF_WIDTH-1:0] x);
    return x[COEF_WIDTH-1] ? COEF_WIDTH'(-x) : COEF_WIDTH'(x);
  endfunction

  function automatic sq_t sqrt_step(sq_t s);
    sq_t              o;
    logic [REM_W+1:0] r2;
    logic [REM_W+1:0] tr;
    r2    = {s.rem, s.rad[DISC_W-1 -: 2]};
    tr    = (REM_W+2)'({s.res, 2'b01});
    o.rad = {s.rad[DISC_W-3:0], 2'b00};
    if (r2 >= tr) begin
      o.rem = REM_W'(r2 - tr);
      o.res = {s.res[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem = REM_W'(r2);
      o.res = {s.res[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic ln_t div_step(ln_t l);
    ln_t            o;
    logic [DEN_W:0] r2;
    o  = l;
    r2 = {l.rem, l.dvd[DVD_W-1]};
    if (r2 >= {1'b0, l.den}) begin
      o.rem = DEN_W'(r2 - {1'b0, l.den});
      o.dvd = {l.dvd[DVD_W-2:0], 1'b1};
    end else begin
      o.rem = r2[DEN_W-1:0];
      o.dvd = {l.dvd[DVD_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

FILE: sv/qrs_disc.sv
// Input register, magnitude products and discriminant of the quadratic root solver.
// Depends on qrs_pkg.
module qrs_disc import qrs_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  logic signed [COEF_WIDTH-1:0] a_i,
  input  logic signed [COEF_WIDTH-1:0] b_i,
  input  logic signed [COEF_WIDTH-1:0] c_i,
  output logic                         vld_o,
  output disc_t                        disc_o
);

  logic                         vld_a_q, vld_b_q, vld_c_q;
  logic signed [COEF_WIDTH-1:0] a_q, b_q, c_q, a2_q, b2_q;
  logic [2*COEF_WIDTH-1:0]      bb_q, ac_q;
  logic                         opp_q;
  disc_t                        disc_d, disc_q;
  logic [DISC_W-1:0]            bb_ext, ac4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_i;
    b_q    <= b_i;
    c_q    <= c_i;
    bb_q   <= coef_mag(b_q) * coef_mag(b_q);
    ac_q   <= coef_mag(a_q) * coef_mag(c_q);
    opp_q  <= a_q[COEF_WIDTH-1] ^ c_q[COEF_WIDTH-1];
    a2_q   <= a_q;
    b2_q   <= b_q;
    disc_q <= disc_d;
  end

  always_comb begin
    bb_ext          = DISC_W'(bb_q);
    ac4             = {ac_q, 2'b00};
    disc_d.sd.a     = a2_q;
    disc_d.sd.b     = b2_q;
    disc_d.sd.degen = (a2_q == '0);
    disc_d.sd.neg   = 1'b0;
    if (opp_q) begin
      disc_d.mag = bb_ext + ac4;
    end else if (ac4 > bb_ext) begin
      disc_d.sd.neg = 1'b1;
      disc_d.mag    = ac4 - bb_ext;
    end else begin
      disc_d.mag = bb_ext - ac4;
    end
    disc_d.sd.zero = !disc_d.sd.neg && (disc_d.mag == '0);
  end

  assign vld_o  = vld_c_q;
  assign disc_o = disc_q;

endmodule

FILE: sv/qrs_sqrt.sv
// Pipelined floor square root of the discriminant, two result bits per stage (one in the last stage).
// Depends on qrs_pkg.
module qrs_sqrt import qrs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  vld_i,
  input  disc_t disc_i,
  output logic  vld_o,
  output root_t root_o
);

  logic  vld_q [SQ_STAGES];
  sq_t   sq_q  [SQ_STAGES];
  side_t sd_q  [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    sq_t   cur, mid, nxt_d;
    logic  vin;
    side_t sin;
    if (s == 0) begin : g_first
      assign cur.rad = disc_i.mag;
      assign cur.res = '0;
      assign cur.rem = '0;
      assign vin     = vld_i;
      assign sin     = disc_i.sd;
    end else begin : g_rest
      assign cur = sq_q[s-1];
      assign vin = vld_q[s-1];
      assign sin = sd_q[s-1];
    end
    assign mid = sqrt_step(cur);
    if (2 * s + 1 < ROOT_W) begin : g_two
      assign nxt_d = sqrt_step(mid);
    end else begin : g_one
      assign nxt_d = mid;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[s] <= nxt_d;
      sd_q[s] <= sin;
    end
  end

  assign vld_o       = vld_q[SQ_STAGES-1];
  assign root_o.root = sq_q[SQ_STAGES-1].res;
  assign root_o.sd   = sd_q[SQ_STAGES-1];

endmodule

FILE: sv/qrs_div.sv
// Numerator setup, two-lane pipelined restoring divider and Q16.16 saturation.
// Depends on qrs_pkg.
module qrs_div import qrs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  vld_i,
  input  root_t root_i,
  output logic  vld_o,
  output res_t  res_o
);

  logic signed [NUM_W:0] rs, bs, n1, n2;
  logic [NUM_W-1:0]      m1, m2;
  dv_t                   nm_d, nm_q;
  logic                  nm_vld_q;
  logic                  vld_q [DV_STAGES];
  dv_t                   dv_q  [DV_STAGES];
  logic                  out_vld_q;
  res_t                  res_d, res_q;

  always_comb begin
    rs = (NUM_W+1)'($signed({1'b0, root_i.root}));
    bs = (NUM_W+1)'(root_i.sd.b);
    if (root_i.sd.neg || root_i.sd.zero) begin
      n1 = -bs;
    end else begin
      n1 = rs - bs;
    end
    if (root_i.sd.neg) begin
      n2 = rs;
    end else if (root_i.sd.zero) begin
      n2 = -bs;
    end else begin
      n2 = -rs - bs;
    end
    m1 = n1[NUM_W] ? NUM_W'(-n1) : NUM_W'(n1);
    m2 = n2[NUM_W] ? NUM_W'(-n2) : NUM_W'(n2);
    nm_d.ln[0].dvd = {m1, {FRAC_OUT{1'b0}}};
    nm_d.ln[1].dvd = {m2, {FRAC_OUT{1'b0}}};
    nm_d.ln[0].rem = '0;
    nm_d.ln[1].rem = '0;
    nm_d.ln[0].den = {coef_mag(root_i.sd.a), 1'b0};
    nm_d.ln[1].den = {coef_mag(root_i.sd.a), 1'b0};
    nm_d.ln[0].neg = n1[NUM_W] ^ root_i.sd.a[COEF_WIDTH-1];
    nm_d.ln[1].neg = root_i.sd.neg ? 1'b0 : (n2[NUM_W] ^ root_i.sd.a[COEF_WIDTH-1]);
    nm_d.m.degen   = root_i.sd.degen;
    if (root_i.sd.neg) begin
      nm_d.m.count = CNT_COMPLEX;
    end else if (root_i.sd.zero) begin
      nm_d.m.count = CNT_REPEAT;
    end else begin
      nm_d.m.count = CNT_DISTINCT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      nm_vld_q  <= vld_i;
      out_vld_q <= vld_q[DV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    nm_q  <= nm_d;
    res_q <= res_d;
  end

  for (genvar s = 0; s < DV_STAGES; s++) begin : g_stage
    dv_t  cur, mid, nxt_d;
    logic vin;
    if (s == 0) begin : g_first
      assign cur = nm_q;
      assign vin = nm_vld_q;
    end else begin : g_rest
      assign cur = dv_q[s-1];
      assign vin = vld_q[s-1];
    end
    assign mid.m = cur.m;
    assign nxt_d.m = mid.m;
    for (genvar l = 0; l < 2; l++) begin : g_lane
      assign mid.ln[l] = div_step(cur.ln[l]);
      if (2 * s + 1 < DVD_W) begin : g_two
        assign nxt_d.ln[l] = div_step(mid.ln[l]);
      end else begin : g_one
        assign nxt_d.ln[l] = mid.ln[l];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[s] <= nxt_d;
    end
  end

  always_comb begin
    logic [1:0]       sat;
    logic [31:0]      val [2];
    logic [DVD_W-1:0] qm;
    dv_t              fin;
    fin = dv_q[DV_STAGES-1];
    for (int l = 0; l < 2; l++) begin
      qm = fin.ln[l].dvd;
      if (qm > (fin.ln[l].neg ? Q_NEG_LIM : Q_POS_LIM)) begin
        sat[l] = 1'b1;
        val[l] = fin.ln[l].neg ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        sat[l] = 1'b0;
        val[l] = fin.ln[l].neg ? 32'(-qm) : qm[31:0];
      end
    end
    res_d.degen = fin.m.degen;
    if (fin.m.degen) begin
      res_d.count = CNT_COMPLEX;
      res_d.v1    = '0;
      res_d.v2    = '0;
      res_d.sat   = 1'b0;
    end else begin
      res_d.count = fin.m.count;
      res_d.v1    = $signed(val[0]);
      res_d.v2    = $signed(val[1]);
      res_d.sat   = |sat;
    end
  end

  assign vld_o = out_vld_q;
  assign res_o = res_q;

endmodule

FILE: sv/quadratic_root_solver.sv
// Top level of the quadratic root solver: discriminant, square root and divider pipelines.
// Depends on qrs_pkg, qrs_disc, qrs_sqrt, qrs_div and quadratic_root_solver_assert.svh.
//
// A transaction is accepted at a rising edge where start is high and busy is low.
// Busy is always low: the block is fully pipelined and accepts one coefficient set
// (coef_quad_i, coef_lin_i, coef_const_i, signed Q8.8) in every cycle.
// Each result is held on the result ports for exactly one cycle, marked by valid_o.
// The latency is set by the 31 register stages: input register, product,
// discriminant, nine square root stages of two root bits each (the last one bit),
// numerator setup, seventeen divider stages of two quotient bits each, and the
// output register.
// Results leave in the order in which transactions were accepted.
// The receiver cannot stall the block, so nothing is ever held back.
// Reset clears all valid bits; transactions in flight at reset are dropped.
// root_count_o is 0 for a complex pair, 1 for a repeated root, 2 for two roots.
// degenerate_o marks a zero leading coefficient, with all other fields zero.
module quadratic_root_solver import qrs_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COEF_WIDTH-1:0] coef_quad_i,
  input  logic signed [COEF_WIDTH-1:0] coef_lin_i,
  input  logic signed [COEF_WIDTH-1:0] coef_const_i,
  output logic                         valid_o,
  output logic [1:0]                   root_count_o,
  output logic signed [31:0]           first_value_o,
  output logic signed [31:0]           second_value_o,
  output logic                         degenerate_o,
  output logic                         saturated_o
);

`include "quadratic_root_solver_assert.svh"

  logic  disc_vld, root_vld, res_vld;
  disc_t disc;
  root_t root;
  res_t  res;
  logic  degen_clean, count_legal;

  assign busy = 1'b0;

  qrs_disc u_disc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start && !busy),
    .a_i    (coef_quad_i),
    .b_i    (coef_lin_i),
    .c_i    (coef_const_i),
    .vld_o  (disc_vld),
    .disc_o (disc)
  );

  qrs_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (disc_vld),
    .disc_i (disc),
    .vld_o  (root_vld),
    .root_o (root)
  );

  qrs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (root_vld),
    .root_i (root),
    .vld_o  (res_vld),
    .res_o  (res)
  );

  assign valid_o        = res_vld;
  assign root_count_o   = res.count;
  assign first_value_o  = res.v1;
  assign second_value_o = res.v2;
  assign degenerate_o   = res.degen;
  assign saturated_o    = res.sat;

  assign degen_clean = (root_count_o == CNT_COMPLEX) && (first_value_o == '0) &&
                       (second_value_o == '0) && !saturated_o;
  assign count_legal = root_count_o inside {CNT_COMPLEX, CNT_REPEAT, CNT_DISTINCT};

  `QRS_ASSERT_DLY(a_latency, start && !busy, LATENCY, valid_o)
  `QRS_ASSERT_IMP(a_degen_zero, valid_o && degenerate_o, degen_clean)
  `QRS_ASSERT_IMP(a_repeat_same, valid_o && (root_count_o == CNT_REPEAT), first_value_o == second_value_o)
  `QRS_ASSERT_IMP(a_count_legal, valid_o, count_legal)

endmodule
